[rtl/core/ebrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrc_pkg
// Shared types and constants of the 8-bit register processor step core.
// ----------------------------------------------------------------------------
package ebrc_pkg;

	localparam int unsigned DATA_W  = 8;
	localparam int unsigned VALUE_W = 17;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned FLAG_W  = 3;

	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_STOP   = 3'd1;
	localparam logic [2:0] ST_END    = 3'd2;
	localparam logic [2:0] ST_BADOP  = 3'd3;
	localparam logic [2:0] ST_BADREG = 3'd4;

	localparam logic [0:0] CFG_START = 1'b0;
	localparam logic [0:0] CFG_END   = 1'b1;

	typedef enum logic [7:0] {
		OP_ADD = 8'd0, OP_SUB = 8'd1, OP_MUL = 8'd2, OP_DIV = 8'd3, OP_MOD = 8'd4,
		OP_STP = 8'd5, OP_LDI = 8'd6, OP_ADR = 8'd7, OP_ADRR = 8'd8, OP_AND = 8'd9,
		OP_OR = 8'd10, OP_XOR = 8'd11, OP_SUBR = 8'd12, OP_MULR = 8'd13,
		OP_DIVR = 8'd14, OP_JMP = 8'd15, OP_NOT = 8'd16, OP_JE = 8'd17,
		OP_JLT = 8'd18, OP_JGT = 8'd19, OP_CMP = 8'd20, OP_INC = 8'd21,
		OP_DEC = 8'd22, OP_JLE = 8'd23, OP_JGE = 8'd24, OP_JNE = 8'd25,
		OP_STI = 8'd26, OP_LDM = 8'd27, OP_STR = 8'd28
	} opcode_t;

	localparam logic [7:0] OP_COUNT = 8'd29;

	// Divider handshake between the core and the shared divide unit.
	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
		logic [7:0] remainder;
	} div_rsp_t;

endpackage

[rtl/core/ebrc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrc_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ebrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/core/ebrc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrc_div
// Restoring 8-bit divider, one quotient bit per cycle. Divisor zero gives 0/0.
// ----------------------------------------------------------------------------
module ebrc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ebrc_pkg::div_req_t  req,
	output ebrc_pkg::div_rsp_t  rsp
);
	import ebrc_pkg::*;

	logic [7:0] quo_q;
	logic [8:0] rem_q;
	logic [7:0] dsr_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic       zero_q;
	logic       done_q;
	logic [8:0] shifted;
	logic [8:0] trial;

	assign shifted = {rem_q[7:0], quo_q[7]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= 9'd0;
			dsr_q  <= req.divisor;
			zero_q <= (req.divisor == 8'd0);
		end else if (busy_q) begin
			if (!trial[8]) begin
				rem_q <= trial;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, zero_q ? 8'd0 : quo_q, zero_q ? 8'd0 : rem_q[7:0]};

	always_ff @(posedge clk) begin
		if (arst_n && rsp.done) begin
			assert (!busy_q) else $error("divider done while still busy");
		end
	end
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("divider done held two cycles");
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == 4'd7 && !req.start) |=> rsp.done)
		else $error("divider did not finish after eight steps");
endmodule

[rtl/core/eight_bit_register_cpu_step_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_register_cpu_step_core
// Steps a small 8-bit processor held in one byte memory: memory writes or
// one fetched-and-executed three-byte instruction per input transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_axis   in         tdata: mode[0], address[8:1], data[16:9]
//  m_axis   out        tdata: value[16:0], status[19:17], exit_code[27:20], flag[30:28]
//  cfg      in         index 0 start_address, 1 program_end
//
// A memory write, and an execute step taken while halted or at the program
// end, go from the accept in S_IDLE straight to the result state S_OUT. An
// execute step passes S_IDLE, the fetch states S_F0 to S_F2, S_EXE and S_OUT;
// DIV, MOD and DIVR add the S_DIVW wait for the bit-serial divider. After
// reset a clearing pass zeros every memory word before the first transaction.
// The result register lets the next transaction in while a result waits; a
// new result holds the core in its result cycle until the register is free.
// ----------------------------------------------------------------------------
module eight_bit_register_cpu_step_core #(
	parameter int MEM_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // mode, address, data
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // value, status, exit_code, flag_code
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import ebrc_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	typedef enum logic [7:0] {
		S_CLR  = 8'b00000001,
		S_IDLE = 8'b00000010,
		S_F0   = 8'b00000100,
		S_F1   = 8'b00001000,
		S_F2   = 8'b00010000,
		S_EXE  = 8'b00100000,
		S_DIVW = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t      state_q;
	logic [AW:0] clr_q;
	logic [7:0]  start_q;
	logic [8:0]  pend_q;
	logic [8:0]  ip_q;
	logic [2:0]  flag_q;
	logic [2:0]  halt_q;
	logic        started_q;
	logic [7:0]  exit_q;
	logic [7:0]  rf_q [4];
	logic [7:0]  op_q, a_q, b_q;
	logic [7:0]  in_addr_q, in_data_q;
	logic        in_mode_q;

	logic        mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]  mem_wdata, mem_rdata;

	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [16:0] val_q;
	logic [30:0] res_q;
	logic        ovalid_q;
	logic        out_load;

	ebrc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	ebrc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {1'b0, res_q};
	assign out_load      = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);

	logic        accept;
	logic [8:0]  ip_eff;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign ip_eff = started_q ? ip_q : {1'b0, start_q};

	logic        ra, rb;
	logic [7:0]  rfa, rfb, rda, rdb;
	assign ra  = (a_q < 8'd4);
	assign rb  = (b_q < 8'd4);
	assign rfa = rf_q[a_q[1:0]];
	assign rfb = rf_q[b_q[1:0]];
	assign rda = ra ? rfa : 8'hFF;
	assign rdb = rb ? rfb : 8'hFF;

	logic        need_ra, need_rab, is_div;
	always_comb begin
		need_ra  = (op_q == OP_LDI) || (op_q == OP_ADR) || (op_q == OP_SUBR)
			|| (op_q == OP_MULR) || (op_q == OP_DIVR) || (op_q == OP_NOT)
			|| (op_q == OP_INC) || (op_q == OP_DEC);
		need_rab = (op_q >= OP_ADRR) && (op_q <= OP_XOR);
		is_div   = (op_q == OP_DIV) || (op_q == OP_MOD) || (op_q == OP_DIVR);
	end

	// CMP difference and divisibility by three of its magnitude. Every power of
	// four is one modulo three, so the base-four digit sum keeps the remainder.
	logic [8:0]  cmp_d;
	logic [7:0]  cmp_mag;
	logic [2:0]  cmp_f;
	logic [3:0]  m3;
	assign cmp_d   = {1'b0, rda} - {1'b0, rdb};
	assign cmp_mag = cmp_d[8] ? 8'(-cmp_d) : cmp_d[7:0];
	always_comb begin
		m3 = 4'(cmp_mag[1:0]) + 4'(cmp_mag[3:2]) + 4'(cmp_mag[5:4]) + 4'(cmp_mag[7:6]);
		if (m3 == 4'd0 || m3 == 4'd3 || m3 == 4'd6 || m3 == 4'd9 || m3 == 4'd12)
			cmp_f = 3'd3;
		else if (cmp_d == 9'd0) cmp_f = 3'd1;
		else if (cmp_d[8])      cmp_f = 3'd2;
		else                    cmp_f = 3'd0;
	end

	logic        take;
	always_comb begin
		case (op_q)
			OP_JE:   take = (flag_q == 3'd1);
			OP_JLT:  take = (flag_q == 3'd2);
			OP_JGT:  take = (flag_q == 3'd0);
			OP_JLE:  take = (flag_q != 3'd0);
			OP_JGE:  take = (flag_q != 3'd2);
			default: take = (flag_q != 3'd1);
		endcase
	end

	logic [15:0] mul_a;
	assign mul_a = (op_q == OP_MUL) ? a_q * b_q : rfa * b_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 8'd0;
		mem_addr  = AW'(ip_q);
		case (state_q)
			S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q[AW-1:0];
			end
			S_IDLE: begin
				mem_addr = AW'(ip_eff);
				if (accept && !s_axis_tdata[0]) begin
					mem_we    = 1'b1;
					mem_addr  = AW'(s_axis_tdata[8:1]);
					mem_wdata = s_axis_tdata[16:9];
				end
			end
			S_F0:  mem_addr = AW'(ip_q + 9'd1);
			S_F1:  mem_addr = AW'(ip_q + 9'd2);
			// Operand B is on the read port now and addresses the LDM read.
			S_F2:  mem_addr = AW'(mem_rdata);
			S_EXE: begin
				mem_addr = AW'(a_q);
				if (halt_q == ST_RUN && op_q == OP_STI) begin
					mem_we = 1'b1;  mem_wdata = b_q;
				end else if (halt_q == ST_RUN && op_q == OP_STR) begin
					mem_we = 1'b1;  mem_wdata = rdb;
				end
			end
			default: mem_addr = AW'(ip_q);
		endcase
	end

	always_comb begin
		dreq.start    = (state_q == S_EXE) && (halt_q == ST_RUN) && is_div
			&& !(need_ra && !ra);
		dreq.dividend = (op_q == OP_DIVR) ? rfa : a_q;
		dreq.divisor  = b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			start_q   <= 8'd10;
			pend_q    <= 9'd40;
			ip_q      <= 9'd0;
			flag_q    <= 3'd0;
			halt_q    <= ST_RUN;
			started_q <= 1'b0;
			exit_q    <= 8'd0;
			op_q      <= 8'd0;
			a_q       <= 8'd0;
			val_q     <= 17'd0;
			res_q     <= '0;
			ovalid_q  <= 1'b0;
			for (int i = 0; i < 4; i++) rf_q[i] <= 8'd0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_START: start_q <= cfg_data[7:0];
					CFG_END:   pend_q  <= cfg_data;
					default:   ;
				endcase
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
				res_q    <= {flag_q, (halt_q == ST_STOP) ? exit_q : 8'd0, halt_q, val_q};
			end else if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MEM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (!s_axis_tdata[0]) begin
							val_q   <= {9'd0, s_axis_tdata[16:9]};
							state_q <= S_OUT;
						end else if (halt_q != ST_RUN) begin
							val_q   <= 17'd0;
							state_q <= S_OUT;
						end else begin
							started_q <= 1'b1;
							ip_q      <= ip_eff;
							if (ip_eff >= pend_q || {1'b0, ip_eff} >= 10'(MEM_DEPTH)) begin
								halt_q  <= ST_END;
								val_q   <= 17'd0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_F0;
							end
						end
					end
				end
				S_F0: begin op_q <= mem_rdata; state_q <= S_F1; end
				S_F1: begin a_q <= mem_rdata; state_q <= S_F2; end
				S_F2: state_q <= S_EXE;
				S_EXE: begin
					state_q <= S_OUT;
					ip_q    <= ip_q + 9'd3;
					val_q   <= 17'd0;
					if (op_q >= OP_COUNT) begin
						halt_q <= ST_BADOP;
					end else if ((need_ra && !ra) || (need_rab && (!ra || !rb))) begin
						halt_q <= ST_BADREG;
					end else if (is_div) begin
						state_q <= S_DIVW;
					end else begin
						case (op_q)
							OP_ADD: begin
								if ({1'b0, a_q} + {1'b0, b_q} > 9'd127) flag_q <= flag_q | 3'd4;
								val_q <= {9'd0, 8'(a_q + b_q)};
							end
							OP_SUB:  val_q <= 17'({9'd0, a_q} - {9'd0, b_q});
							OP_MUL, OP_MULR: val_q <= {1'b0, mul_a};
							OP_STP: begin halt_q <= ST_STOP; exit_q <= a_q; end
							OP_LDI: begin rf_q[a_q[1:0]] <= b_q; val_q <= {9'd0, b_q}; end
							OP_ADR:  val_q <= {8'd0, {1'b0, rfa} + {1'b0, b_q}};
							OP_ADRR: val_q <= {8'd0, {1'b0, rfa} + {1'b0, rfb}};
							OP_AND:  val_q <= {9'd0, rfa & rfb};
							OP_OR:   val_q <= {9'd0, rfa | rfb};
							OP_XOR:  val_q <= {9'd0, rfa ^ rfb};
							OP_SUBR: val_q <= 17'({9'd0, rfa} - {9'd0, b_q});
							OP_JMP: begin ip_q <= {1'b0, a_q}; val_q <= {9'd0, a_q}; end
							OP_NOT:  val_q <= {9'd0, ~rfa};
							OP_CMP: begin flag_q <= cmp_f; val_q <= {14'd0, cmp_f}; end
							OP_INC: begin
								rf_q[a_q[1:0]] <= rfa + 8'd1; val_q <= {9'd0, 8'(rfa + 8'd1)};
							end
							OP_DEC: begin
								rf_q[a_q[1:0]] <= rfa - 8'd1; val_q <= {9'd0, 8'(rfa - 8'd1)};
							end
							OP_STI:  val_q <= {9'd0, b_q};
							OP_LDM: begin
								val_q <= {9'd0, mem_rdata};
								if (ra) rf_q[a_q[1:0]] <= mem_rdata;
							end
							OP_STR:  val_q <= {9'd0, rdb};
							default: begin
								if (take) begin
									ip_q  <= {1'b0, a_q};
									val_q <= {9'd0, a_q};
								end else begin
									val_q <= 17'd255;
								end
							end
						endcase
					end
				end
				S_DIVW: begin
					if (drsp.done) begin
						val_q   <= {9'd0, (op_q == OP_MOD) ? drsp.remainder : drsp.quotient};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// b is the third fetch; it is on the read port in S_F2 and is held for S_EXE.
	always_ff @(posedge clk) begin
		if (state_q == S_F2) b_q <= mem_rdata;
	end

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && ovalid_q && !m_axis_tready) |=> (state_q == S_OUT))
		else $error("result lost while output stalled");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(halt_q) != ST_RUN && $past(state_q) != S_CLR) |-> $stable(halt_q))
		else $error("halt status changed after halt");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_axis_tready) |=> (ovalid_q && $stable(res_q)))
		else $error("result changed while stalled");
endmodule
